FILE: hw/rtl/tile_pkg.sv
`timescale 1ns / 1ps

package tile_pkg;

    // Command carried in tuser of an input request.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic clr_en;   // write zeros at the sweep counter and advance it
        logic ltr_go;   // accepted letter starts a child lookup
        logic look;     // child read data is valid: resolve the letter
        logic fin;      // key mark read data is valid: load the result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_done; // sweep counter is at the last entry
        logic ltr_skip; // letter on the input is ignored (failed key or out of range)
        logic out_free; // result register can take a new result this cycle
    } t_dp_sts;

endpackage

FILE: hw/rtl/tile_ram.sv
`timescale 1ns / 1ps

module tile_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tile_ctrl.sv
`timescale 1ns / 1ps

module tile_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    input  tile_pkg::t_dp_sts i_sts,
    output logic             o_ready,
    output tile_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_MARK  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_last) begin
                        n_state = S_MARK;
                    end else if (!i_sts.ltr_skip) begin
                        o_cmd.ltr_go = 1'b1;
                        n_state      = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_IDLE;
            end
            S_MARK: begin
                // Wait here while the previous result is still unclaimed.
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tile_dp.sv
`timescale 1ns / 1ps

module tile_dp #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_NODES     = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [4:0]        i_letter,
    input  logic              i_out_ready,
    input  tile_pkg::t_dp_cmd i_cmd,
    output tile_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    output logic              o_found,
    output logic              o_pool_full
);

    // Letters above 31 cannot arrive, so at most five letter bits address a row.
    localparam int LTR_W       = (ALPHABET_SIZE > 32) ? 5 : $clog2(ALPHABET_SIZE);
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NFREE_W     = $clog2(MAX_NODES + 1);
    localparam int SLOT_W      = NODE_W + LTR_W;
    localparam int CHILD_DEPTH = MAX_NODES << LTR_W;

    logic [NODE_W-1:0]  r_cursor;
    logic [NODE_W-1:0]  n_cursor;
    logic [NFREE_W-1:0] r_next_free;
    logic [NFREE_W-1:0] n_next_free;
    logic               r_failed;
    logic               n_failed;
    logic               r_command;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_clr_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_found;
    logic               r_pool_full;

    logic [SLOT_W-1:0]  in_slot;
    logic               ltr_in_range;
    logic [NODE_W-1:0]  child_rdata;
    logic               child_we;
    logic [SLOT_W-1:0]  child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic               mark_rdata;
    logic               mark_we;
    logic [NODE_W-1:0]  mark_waddr;
    logic               alloc;
    logic               pool_empty;
    logic               mark_set;

    assign ltr_in_range = {2'b00, i_letter} < 7'(ALPHABET_SIZE);
    assign in_slot      = {r_cursor, i_letter[LTR_W-1:0]};
    assign pool_empty   = r_next_free == NFREE_W'(MAX_NODES);

    assign alloc    = i_cmd.look && (child_rdata == '0)
                      && (r_command == tile_pkg::CMD_INSERT) && !pool_empty;
    assign mark_set = i_cmd.fin && (r_command == tile_pkg::CMD_INSERT) && !r_failed;

    assign o_sts.clr_done = r_clr_cnt == SLOT_W'(CHILD_DEPTH - 1);
    assign o_sts.ltr_skip = r_failed || !ltr_in_range;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign child_we    = i_cmd.clr_en || alloc;
    assign child_waddr = i_cmd.clr_en ? r_clr_cnt : r_slot;
    assign child_wdata = i_cmd.clr_en ? '0 : r_next_free[NODE_W-1:0];

    assign mark_we    = (i_cmd.clr_en && (r_clr_cnt < SLOT_W'(MAX_NODES))) || mark_set;
    assign mark_waddr = i_cmd.clr_en ? r_clr_cnt[NODE_W-1:0] : r_cursor;

    tile_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_raddr (in_slot),
        .o_rdata (child_rdata)
    );

    tile_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NODES)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (!i_cmd.clr_en),
        .i_raddr (r_cursor),
        .o_rdata (mark_rdata)
    );

    always_comb begin
        n_cursor    = r_cursor;
        n_next_free = r_next_free;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.look) begin
            if (child_rdata != '0) begin
                n_cursor = child_rdata;
            end else if (alloc) begin
                n_cursor    = r_next_free[NODE_W-1:0];
                n_next_free = r_next_free + NFREE_W'(1);
            end else begin
                n_failed = 1'b1;
            end
        end
        if (i_cmd.fin) begin
            n_cursor    = '0;
            n_failed    = 1'b0;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_next_free <= NFREE_W'(1);
            r_failed    <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor    <= n_cursor;
            r_next_free <= n_next_free;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
            if (i_cmd.clr_en) begin
                r_clr_cnt <= r_clr_cnt + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_command <= i_command;
        end
        if (i_cmd.ltr_go) begin
            r_slot <= in_slot;
        end
        if (i_cmd.fin) begin
            if (r_command == tile_pkg::CMD_LOOKUP) begin
                r_found     <= !r_failed && mark_rdata;
                r_pool_full <= 1'b0;
            end else begin
                r_found     <= !r_failed;
                r_pool_full <= r_failed;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_pool_full = r_pool_full;

endmodule

FILE: hw/rtl/trie_insert_lookup_engine_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata[4:0] letter, tlast is_end,          tvalid / tready
//                tuser command (0 insert, 1 lookup)
// m_axis    out  tdata[0] found, tdata[1] pool_full        tvalid / tready
//
// A letter request runs as a child-table read, then the cursor update with an
// optional write of a newly allocated child. A terminator runs as a key mark read,
// then a result load; an ignored letter is taken without a lookup. After reset a
// clearing pass over MAX_NODES * 2**ceil(log2(ALPHABET_SIZE)) child entries (at
// most 32 letter slots per node) runs one entry per cycle and no request is taken.
// A terminator waits only while the previous result sits unclaimed in the output.

module trie_insert_lookup_engine_unit #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_NODES     = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic       s_axis_tlast,   // is_end
    input  logic       s_axis_tuser,   // [0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] found, [1] pool_full, [7:2] zero
);

    tile_pkg::t_dp_cmd dp_cmd;
    tile_pkg::t_dp_sts dp_sts;
    logic              in_accept;
    logic              found;
    logic              pool_full;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // The controller sequences clearing, letter walks and terminators.
    tile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .i_sts   (dp_sts),
        .o_ready (s_axis_tready),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the node pool, the cursor and the result register.
    tile_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_NODES     (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_command   (s_axis_tuser),
        .i_letter    (s_axis_tdata[4:0]),
        .i_out_ready (m_axis_tready),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (m_axis_tvalid),
        .o_found     (found),
        .o_pool_full (pool_full)
    );

    assign m_axis_tdata = {6'b000000, pool_full, found};

    // No request is taken while the pool is being cleared.
    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.clr_en |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // A child lookup resolves in the cycle after its letter was taken.
    a_look_follows_letter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.look |-> $past(in_accept && !s_axis_tlast))
        else $error("child lookup without a preceding letter");

    // Loading a result always presents it on the next cycle.
    a_fin_shows_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.fin |=> m_axis_tvalid)
        else $error("result not presented after load");

    // Datapath commands never overlap.
    a_cmd_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.clr_en, dp_cmd.ltr_go, dp_cmd.look, dp_cmd.fin}))
        else $error("overlapping datapath commands");

endmodule
